// ----- sv/ght_pkg.sv -----
// shared types and constants for the generational handle table
package ght_pkg;

  localparam int SLOTS = 4096;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int HALF_W = 32;
  localparam int TYPE_W = 64;
  localparam int HANDLE_W = 2 * HALF_W;

  typedef enum logic [1:0] {
    CMD_CREATE   = 2'd0,
    CMD_LOOKUP   = 2'd1,
    CMD_SET_TYPE = 2'd2,
    CMD_DESTROY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_BAD     = 2'd2,
    STS_NOALLOC = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // one slot entry
  typedef struct packed {
    logic [HALF_W-1:0] address;
    logic [HALF_W-1:0] generation;
    logic [TYPE_W-1:0] type_word;
  } slot_t;

  // one free-stack entry: slot index and the generation it will reuse
  typedef struct packed {
    logic [HALF_W-1:0] generation;
    logic [IDX_W-1:0]  idx;
  } free_t;

  // write port of a memory
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } wr_ctl_t;

endpackage

// ----- sv/ght_slot_mem.sv -----
// slot memory: address, generation and type of every slot, one read and one write port
module ght_slot_mem (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ght_pkg::IDX_W-1:0] rd_idx,
  output ght_pkg::slot_t      rd_data,
  input  ght_pkg::wr_ctl_t    wr,
  input  ght_pkg::slot_t      wr_data
);
  import ght_pkg::*;

  slot_t mem [SLOTS];

  // synchronous write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ----- sv/ght_free_stack.sv -----
// free-slot stack memory, one read and one write port
module ght_free_stack (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ght_pkg::IDX_W-1:0] rd_idx,
  output ght_pkg::free_t      rd_data,
  input  ght_pkg::wr_ctl_t    wr,
  input  ght_pkg::free_t      wr_data
);
  import ght_pkg::*;

  free_t mem [SLOTS];

  // synchronous write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ----- sv/generational_handle_table_core.sv -----
// top level of the generational handle table: command sequencer and result register
//
//  channel | valid     | ready     | word
//  --------+-----------+-----------+--------------------------------------------------
//  in      | in_valid  | in_ready  | cmd, handle_in, object_address, type_word
//  out     | out_valid | out_ready | status, handle_out, address_out, type_out, is_valid
//
// the accept cycle (ST_IDLE) reads the slot and free-stack memories, and ST_EXEC
// checks the handle and writes the slot entry back (one read-modify-write
// through the slot memory's read and write ports), then a new word is taken.
// ST_EXEC waits while the result register is still full and not being taken.
// reset clears the counters and handshake state only; the memories need no clearing
// pass, since only slots below the used count or on the free stack are ever used.
module generational_handle_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] handle_in,
  input  logic [31:0] object_address,
  input  logic [63:0] type_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] handle_out,
  output logic [31:0] address_out,
  output logic [63:0] type_out,
  output logic        is_valid
);
  import ght_pkg::*;

  state_t state, state_next;

  // captured command word
  cmd_t                item_cmd;
  logic [HANDLE_W-1:0] item_handle;
  logic [HALF_W-1:0]   item_address;
  logic [TYPE_W-1:0]   item_type;

  logic [CNT_W-1:0] used_count, used_count_next;
  logic [CNT_W-1:0] free_depth, free_depth_next;

  logic    accept, exec_go;
  slot_t   slot_rd, slot_wr;
  free_t   free_rd, free_wr;
  wr_ctl_t slot_ctl, free_ctl;
  logic [IDX_W-1:0] free_rd_idx;

  logic          match;
  logic [HALF_W-1:0] gen_inc;
  status_t       res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [HALF_W-1:0]   res_address;
  logic [TYPE_W-1:0]   res_type;
  logic          res_valid;

  assign accept      = in_valid && in_ready;
  assign exec_go     = (state == ST_EXEC) && (!out_valid || out_ready);
  assign free_rd_idx = IDX_W'(free_depth - CNT_W'(1));

  ght_slot_mem u_slot_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_idx  (handle_in[IDX_W-1:0]),
    .rd_data (slot_rd),
    .wr      (slot_ctl),
    .wr_data (slot_wr)
  );

  ght_free_stack u_free_stack (
    .clk     (clk),
    .rd_en   (accept),
    .rd_idx  (free_rd_idx),
    .rd_data (free_rd),
    .wr      (free_ctl),
    .wr_data (free_wr)
  );

  // state register and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used_count <= '0;
      free_depth <= '0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      free_depth <= free_depth_next;
    end
  end

  // capture the command word
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd     <= cmd_t'(cmd);
      item_handle  <= handle_in;
      item_address <= object_address;
      item_type    <= type_word;
    end
  end

  // handle check against the slot just read
  assign match = (item_handle != '0)
              && (item_handle[HALF_W-1:IDX_W] == '0)
              && ({1'b0, item_handle[IDX_W-1:0]} < used_count)
              && (slot_rd.generation == item_handle[HANDLE_W-1:HALF_W]);

  // next generation, skipping zero
  always_comb begin
    gen_inc = slot_rd.generation + HALF_W'(1);
    if (gen_inc == '0) begin
      gen_inc = HALF_W'(1);
    end
  end

  // sequencer: next state, memory writes and result
  always_comb begin
    state_next      = state;
    in_ready        = (state == ST_IDLE);
    used_count_next = used_count;
    free_depth_next = free_depth;
    slot_ctl        = '{en: 1'b0, idx: item_handle[IDX_W-1:0]};
    slot_wr         = slot_rd;
    free_ctl        = '{en: 1'b0, idx: free_depth[IDX_W-1:0]};
    free_wr         = '{generation: gen_inc, idx: item_handle[IDX_W-1:0]};
    res_status      = STS_OK;
    res_handle      = '0;
    res_address     = '0;
    res_type        = '0;
    res_valid       = 1'b0;

    unique case (item_cmd)
      CMD_CREATE: begin
        priority if (item_address == '0) begin
          res_status = STS_NOALLOC;
        end else if (free_depth != '0) begin
          // reuse a freed slot with its advanced generation
          slot_ctl.en     = exec_go;
          slot_ctl.idx    = free_rd.idx;
          slot_wr         = '{address: item_address, generation: free_rd.generation,
                              type_word: '0};
          res_handle      = {free_rd.generation, {(HALF_W-IDX_W){1'b0}}, free_rd.idx};
          if (exec_go) begin
            free_depth_next = free_depth - CNT_W'(1);
          end
        end else if (used_count == CNT_W'(SLOTS)) begin
          res_status = STS_FULL;
        end else begin
          // take the next never-used slot
          slot_ctl.en  = exec_go;
          slot_ctl.idx = used_count[IDX_W-1:0];
          slot_wr      = '{address: item_address, generation: HALF_W'(1), type_word: '0};
          res_handle   = {HALF_W'(1), {(HALF_W-IDX_W){1'b0}}, used_count[IDX_W-1:0]};
          if (exec_go) begin
            used_count_next = used_count + CNT_W'(1);
          end
        end
      end
      CMD_LOOKUP: begin
        if (match && slot_rd.address != '0) begin
          res_address = slot_rd.address;
          res_type    = slot_rd.type_word;
          res_valid   = 1'b1;
        end else begin
          res_status = STS_BAD;
        end
      end
      CMD_SET_TYPE: begin
        if (match) begin
          slot_ctl.en       = exec_go;
          slot_wr.type_word = item_type;
        end else begin
          res_status = STS_BAD;
        end
      end
      CMD_DESTROY: begin
        if (match && slot_rd.address != '0) begin
          slot_ctl.en = exec_go;
          slot_wr     = '{address: '0, generation: gen_inc, type_word: '0};
          if (free_depth != CNT_W'(SLOTS)) begin
            free_ctl.en = exec_go;
            if (exec_go) begin
              free_depth_next = free_depth + CNT_W'(1);
            end
          end
        end else begin
          res_status = STS_BAD;
        end
      end
      default: begin
        res_status = STS_BAD;
      end
    endcase

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      status      <= res_status;
      handle_out  <= res_handle;
      address_out <= res_address;
      type_out    <= res_type;
      is_valid    <= res_valid;
    end
  end

  // freed slots are a subset of used slots
  a_free_le_used: assert property (@(posedge clk) disable iff (rst)
    free_depth <= used_count)
    else $error("free stack deeper than used slot count");

  // used count never passes the table size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(SLOTS))
    else $error("used slot count beyond table size");

  // a valid lookup result always reports ok
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_valid) |-> (status == STS_OK))
    else $error("valid lookup with non-ok status");

  // a returned handle carries a nonzero generation and ok status
  a_handle_gen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && handle_out != '0) |->
      (status == STS_OK && handle_out[HANDLE_W-1:HALF_W] != '0))
    else $error("handle returned with zero generation or bad status");

endmodule
